@@ design/e131_data_packet_framer_assert.svh @@
// Assertion helpers for the E1.31 data packet framer.
// Each macro expands to one labeled concurrent assertion on clk_i, off in reset.
`ifndef E131_DATA_PACKET_FRAMER_ASSERT_SVH
`define E131_DATA_PACKET_FRAMER_ASSERT_SVH
// Same-cycle implication.
`define E131F_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define E131F_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ design/e131f_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// e131f_pkg
// Types, constants and header byte map shared by the E1.31 packet framer.
// ---------------------------------------------------------------------------
package e131f_pkg;

  localparam int unsigned MaxSlotsDef  = 512;
  localparam int unsigned NameLimitDef = 63;
  localparam int unsigned NameRows     = 8;
  localparam int unsigned HdrLastWord  = 14;
  localparam int unsigned HdrTailBytes = 6;
  localparam int unsigned NameRowBase  = 5;

  // Register indexes of the configuration port
  localparam logic [2:0] CfgUniverse = 3'd0;
  localparam logic [2:0] CfgPriority = 3'd1;
  localparam logic [2:0] CfgCidUpper = 3'd2;
  localparam logic [2:0] CfgCidLower = 3'd3;
  localparam logic [2:0] CfgSlots    = 3'd4;

  localparam logic [15:0] UniverseMax = 16'd63999;

  localparam logic [7:0] AcnIdent [12] = '{
    8'h41, 8'h53, 8'h43, 8'h2D, 8'h45, 8'h31,
    8'h2E, 8'h31, 8'h37, 8'h00, 8'h00, 8'h00
  };

  typedef struct packed {
    logic [15:0] universe;
    logic [7:0]  prio;
    logic [63:0] cid_upper;
    logic [63:0] cid_lower;
    logic [9:0]  slots;
  } cfg_t;

  typedef struct packed {
    logic       en;
    logic [5:0] idx;
    logic [7:0] data;
  } name_wr_t;

  // Flags and length field of one PDU layer
  function automatic logic [15:0] flags_len(input logic [10:0] len);
    return 16'h7000 | ({5'h00, len} & 16'h0FFF);
  endfunction

  // Build header word k (bytes 8k..8k+7); nw holds the name bytes aligned to it
  function automatic logic [63:0] hdr_word(input logic [3:0] k, input cfg_t c,
                                           input logic [7:0] seq,
                                           input logic [63:0] nw,
                                           input logic [5:0] nlen);
    logic [63:0] w;
    logic [6:0]  off;
    logic [6:0]  ni;
    logic [7:0]  b;
    logic [10:0] total;
    logic [15:0] fr;
    logic [15:0] ff;
    logic [15:0] fd;
    logic [15:0] pc;
    total = 11'd126 + {1'b0, c.slots};
    fr    = flags_len(total - 11'd16);
    ff    = flags_len(total - 11'd38);
    fd    = flags_len(total - 11'd115);
    pc    = {6'h00, c.slots} + 16'd1;
    w     = '0;
    for (int p = 0; p < 8; p++) begin
      off = {k, 3'b000} + 7'(p);
      ni  = off - 7'd44;
      b   = 8'h00;
      case (off) inside
        7'd1:          b = 8'h10;
        [7'd4:7'd15]:  b = AcnIdent[4'(off - 7'd4)];
        7'd16:         b = fr[15:8];
        7'd17:         b = fr[7:0];
        7'd21:         b = 8'h04;
        [7'd22:7'd29]: b = c.cid_upper[8*(29 - int'(off)) +: 8];
        [7'd30:7'd37]: b = c.cid_lower[8*(37 - int'(off)) +: 8];
        7'd38:         b = ff[15:8];
        7'd39:         b = ff[7:0];
        7'd43:         b = 8'h02;
        [7'd44:7'd106]: b = (ni < {1'b0, nlen}) ? nw[8*(7 - p) +: 8] : 8'h00;
        7'd108:        b = c.prio;
        7'd111:        b = seq;
        7'd113:        b = c.universe[15:8];
        7'd114:        b = c.universe[7:0];
        7'd115:        b = fd[15:8];
        7'd116:        b = fd[7:0];
        7'd117:        b = 8'h02;
        7'd118:        b = 8'hA1;
        7'd122:        b = 8'h01;
        7'd123:        b = pc[15:8];
        7'd124:        b = pc[7:0];
        default:       b = 8'h00;
      endcase
      w[8*(7 - p) +: 8] = b;
    end
    return w;
  endfunction

endpackage

@@ design/e131f_name_store.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// e131f_name_store
// Source name memory, eight rows of eight bytes, big-endian within a row.
// Reads one row a cycle and aligns two rows to a header word.
// ---------------------------------------------------------------------------
module e131f_name_store import e131f_pkg::*; (
  input  logic        clk_i,
  input  name_wr_t    wr_i,
  input  logic [2:0]  rd_row_i,
  input  logic        shift_i,
  output logic [63:0] name_word_o
);

  logic [63:0] mem_q [NameRows];
  logic [63:0] rd_q;
  logic [63:0] prev_q;

  // Write one byte lane, read one row, hold the previous row
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.idx[5:3]][8*(7 - int'(wr_i.idx[2:0])) +: 8] <= wr_i.data;
    end
    rd_q <= mem_q[rd_row_i];
    if (shift_i) begin
      prev_q <= rd_q;
    end
  end

  // Name starts at header byte 44: four bytes of each row fall in one word
  assign name_word_o = {prev_q[31:0], rd_q[63:32]};

endmodule

@@ design/e131_data_packet_framer.sv @@
`timescale 1ns / 1ps
`include "e131_data_packet_framer_assert.svh"
// ---------------------------------------------------------------------------
// e131_data_packet_framer
// Frames E1.31 data packets into 64-bit big-endian words.
//
//   channel | direction | handshake              | payload
//   in      | sink      | in_valid_i / in_stall_o   | item_kind, data_byte, seq, name_end
//   out     | source    | out_valid_o / out_stall_i | packet_word, valid_bytes, last, error
//   cfg     | sink      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// Name bytes and later slot bytes are accepted back to back while the input is not stalled.
// The first slot byte of a good packet starts the header: for each header word
// a row read of the name memory (S_HRD), then the word build (S_HWR), which waits
// while the output is held, and last the tail state that packs the slot byte.
// Reset is asynchronous, active low; the name memory is not cleared.
// Input stalls while the header runs and while the output register is held.
// ---------------------------------------------------------------------------
module e131_data_packet_framer import e131f_pkg::*; #(
  parameter int unsigned MAX_SLOTS  = MaxSlotsDef,
  parameter int unsigned NAME_LIMIT = NameLimitDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        item_kind_i,
  input  logic [7:0]  data_byte_i,
  input  logic [7:0]  sequence_number_i,
  input  logic        name_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] packet_word_o,
  output logic [3:0]  valid_bytes_o,
  output logic        packet_last_o,
  output logic        packet_error_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  typedef enum logic [1:0] {S_IDLE, S_HRD, S_HWR, S_TAIL} state_e;

  state_e      state_q;
  cfg_t        cfg_q;
  logic [5:0]  name_len_q;
  logic        name_done_q;
  logic [9:0]  slot_pos_q;
  logic [63:0] pend_q;
  logic [3:0]  pcnt_q;
  logic        drop_q;
  logic [3:0]  k_q;
  logic [7:0]  seq_q;
  logic [7:0]  byte_q;
  logic        fin_q;
  logic        out_valid_q;
  logic [63:0] word_q;
  logic [3:0]  vb_q;
  logic        last_q;
  logic        err_q;

  logic        out_free;
  logic        in_acc;
  logic        name_acc;
  logic        slot_acc;
  name_wr_t    name_wr;
  logic [3:0]  krow;
  logic        name_shift;
  logic [63:0] name_word;
  logic [9:0]  end_pos;
  logic [10:0] pos;
  logic        final_slot;
  logic        bad;
  logic [7:0]  push_byte;
  logic        push_fin;
  logic [63:0] push_word;
  logic [3:0]  pcnt_inc;
  logic        emit_now;
  logic        out_load;
  logic [63:0] hw;
  logic [63:0] w15;

  // Handshakes
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign name_acc   = in_acc && !item_kind_i;
  assign slot_acc   = in_acc && item_kind_i;
  assign cfg_ready_o = 1'b1;

  // Name store access
  always_comb begin
    name_wr.en   = name_acc && (name_done_q || (name_len_q < 6'(NAME_LIMIT)));
    name_wr.idx  = name_done_q ? 6'd0 : name_len_q;
    name_wr.data = data_byte_i;
  end
  assign krow       = k_q - 4'(NameRowBase);
  assign name_shift = (state_q == S_HWR) && out_free;

  e131f_name_store u_name (
    .clk_i      (clk_i),
    .wr_i       (name_wr),
    .rd_row_i   (krow[2:0]),
    .shift_i    (name_shift),
    .name_word_o(name_word)
  );

  // Packet position and checks
  assign end_pos    = (cfg_q.slots == 10'd0) ? 10'd1 : cfg_q.slots;
  assign pos        = {1'b0, slot_pos_q} + 11'd1;
  assign final_slot = pos >= {1'b0, end_pos};
  assign bad = (cfg_q.universe == 16'd0) || (cfg_q.universe > UniverseMax) ||
               (cfg_q.slots == 10'd0) || ({1'b0, cfg_q.slots} > 11'(MAX_SLOTS)) ||
               (name_len_q == 6'd0);

  // Byte packing
  assign push_byte = (state_q == S_TAIL) ? byte_q : data_byte_i;
  assign push_fin  = (state_q == S_TAIL) ? fin_q : final_slot;
  assign push_word = pend_q | ({push_byte, 56'h0} >> {pcnt_q, 3'b000});
  assign pcnt_inc  = pcnt_q + 4'd1;
  assign emit_now  = (pcnt_inc == 4'd8) || push_fin;

  // Load the output register with a new result
  assign out_load = (slot_acc && ((slot_pos_q == 10'd0) ? bad : (!drop_q && emit_now))) ||
                    ((state_q == S_HWR) && out_free) ||
                    ((state_q == S_TAIL) && out_free && emit_now);

  // Header words
  assign hw  = hdr_word(k_q, cfg_q, seq_q, name_word, name_len_q);
  assign w15 = hdr_word(4'd15, cfg_q, seq_q, name_word, name_len_q);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.universe  <= 16'd1;
      cfg_q.prio      <= 8'd100;
      cfg_q.cid_upper <= '0;
      cfg_q.cid_lower <= '0;
      cfg_q.slots     <= 10'd512;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgUniverse: cfg_q.universe  <= cfg_data_i[15:0];
        CfgPriority: cfg_q.prio      <= cfg_data_i[7:0];
        CfgCidUpper: cfg_q.cid_upper <= cfg_data_i;
        CfgCidLower: cfg_q.cid_lower <= cfg_data_i;
        CfgSlots:    cfg_q.slots     <= cfg_data_i[9:0];
        default:     ;
      endcase
    end
  end

  // Sequencer, packing state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      name_len_q  <= '0;
      name_done_q <= 1'b0;
      slot_pos_q  <= '0;
      pend_q      <= '0;
      pcnt_q      <= '0;
      drop_q      <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      seq_q       <= '0;
      byte_q      <= '0;
      fin_q       <= 1'b0;
      word_q      <= '0;
      vb_q        <= '0;
      last_q      <= 1'b0;
      err_q       <= 1'b0;
    end else begin
      // Hold a new result, drop the old one once taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (name_acc) begin
            if (name_done_q) begin
              name_len_q <= 6'd1;
            end else if (name_wr.en) begin
              name_len_q <= name_len_q + 6'd1;
            end
            name_done_q <= name_end_i;
          end
          if (slot_acc) begin
            slot_pos_q <= final_slot ? 10'd0 : pos[9:0];
            if (slot_pos_q == 10'd0) begin
              if (bad) begin
                word_q      <= '0;
                vb_q        <= 4'd0;
                last_q      <= 1'b1;
                err_q       <= 1'b1;
                pend_q      <= '0;
                pcnt_q      <= '0;
                drop_q      <= !final_slot;
              end else begin
                drop_q  <= 1'b0;
                seq_q   <= sequence_number_i;
                byte_q  <= data_byte_i;
                fin_q   <= final_slot;
                k_q     <= '0;
                state_q <= S_HRD;
              end
            end else if (!drop_q) begin
              if (emit_now) begin
                word_q      <= push_word;
                vb_q        <= pcnt_inc;
                last_q      <= push_fin;
                err_q       <= 1'b0;
                pend_q      <= '0;
                pcnt_q      <= '0;
              end else begin
                pend_q <= push_word;
                pcnt_q <= pcnt_inc;
              end
            end else if (final_slot) begin
              drop_q <= 1'b0;
            end
          end
        end
        S_HRD: begin
          state_q <= S_HWR;
        end
        S_HWR: begin
          if (out_free) begin
            word_q      <= hw;
            vb_q        <= 4'd8;
            last_q      <= 1'b0;
            err_q       <= 1'b0;
            if (k_q == 4'(HdrLastWord)) begin
              pend_q  <= w15;
              pcnt_q  <= 4'(HdrTailBytes);
              state_q <= S_TAIL;
            end else begin
              k_q     <= k_q + 4'd1;
              state_q <= S_HRD;
            end
          end
        end
        S_TAIL: begin
          if (out_free) begin
            if (emit_now) begin
              word_q      <= push_word;
              vb_q        <= pcnt_inc;
              last_q      <= push_fin;
              err_q       <= 1'b0;
              pend_q      <= '0;
              pcnt_q      <= '0;
            end else begin
              pend_q <= push_word;
              pcnt_q <= pcnt_inc;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign packet_word_o  = word_q;
  assign valid_bytes_o  = vb_q;
  assign packet_last_o  = last_q;
  assign packet_error_o = err_q;

  `E131F_ASSERT_IMP(a_err_shape, out_valid_o && packet_error_o, (valid_bytes_o == 4'd0) && packet_last_o, "error result must be empty and last")
  `E131F_ASSERT_IMP(a_data_count, out_valid_o && !packet_error_o, (valid_bytes_o != 4'd0) && (valid_bytes_o <= 4'd8), "data word byte count out of range")
  `E131F_ASSERT_IMP(a_busy_stall, state_q != S_IDLE, in_stall_o, "input taken during header")
  `E131F_ASSERT_NXT(a_read_step, state_q == S_HRD, state_q == S_HWR, "header read not followed by word build")
  `E131F_ASSERT_IMP(a_pend_count, 1'b1, pcnt_q < 4'd8, "pending word overfilled")

endmodule
